[rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and the control program of the thread slot
// scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int THREAD_SLOTS  = 16;
    localparam int PROCESS_SLOTS = 16;
    localparam int PROGRAM_COUNT = 16;

    localparam int TIDX_W = $clog2(THREAD_SLOTS);
    localparam int PIDX_W = $clog2(PROCESS_SLOTS);
    localparam int SCAN_W = (TIDX_W > PIDX_W) ? TIDX_W : PIDX_W;
    localparam int CNT_W  = 5;

    localparam int OP_W     = 3;
    localparam int PROG_W   = 4;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int STEP_W   = 4;

    localparam logic [WORD_W-1:0] VERSION_WORD = 32'h0001_0000;

    // Request codes
    localparam logic [OP_W-1:0] REQ_VERSION   = 3'd0;
    localparam logic [OP_W-1:0] REQ_CREATE    = 3'd1;
    localparam logic [OP_W-1:0] REQ_YIELD     = 3'd2;
    localparam logic [OP_W-1:0] REQ_TERMINATE = 3'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ERROR   = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SET_VER,
        OP_SET_ILL,
        OP_SET_ERR,
        OP_SCAN_INIT,
        OP_LATCH_PROC,
        OP_COMMIT,
        OP_SCAN_INIT_RR,
        OP_SET_RUN,
        OP_KILL
    } t_dp_op;

    // Sequencing kinds
    typedef enum logic [2:0] {
        K_NEXT,
        K_GOTO,
        K_IF,
        K_SCAN,
        K_EMIT
    } t_kind;

    typedef enum logic {
        C_PROG_BAD,
        C_RUN_ABSENT
    } t_cond;

    typedef enum logic [1:0] {
        PR_NONE,
        PR_P_FREE,
        PR_T_FREE,
        PR_T_USED
    } t_pred;

    typedef struct packed {
        t_dp_op            op;
        t_kind             kind;
        t_cond             cond;
        t_pred             pred;
        logic [STEP_W-1:0] tgt_a;
        logic [STEP_W-1:0] tgt_b;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic   run;
        t_dp_op op;
        t_pred  pred;
        logic   scan_adv;
        logic   emit;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic hit;
        logic scan_last;
        logic prog_bad;
        logic run_absent;
        logic out_busy;
    } t_flags;

    // Program addresses
    localparam logic [STEP_W-1:0] S_VER      = 4'd0;
    localparam logic [STEP_W-1:0] S_ILL      = 4'd1;
    localparam logic [STEP_W-1:0] S_CRE      = 4'd2;
    localparam logic [STEP_W-1:0] S_CRE_PSC  = 4'd3;
    localparam logic [STEP_W-1:0] S_CRE_LAT  = 4'd4;
    localparam logic [STEP_W-1:0] S_CRE_TSC  = 4'd5;
    localparam logic [STEP_W-1:0] S_CRE_COM  = 4'd6;
    localparam logic [STEP_W-1:0] S_YLD      = 4'd7;
    localparam logic [STEP_W-1:0] S_YLD_SC   = 4'd8;
    localparam logic [STEP_W-1:0] S_RUN      = 4'd9;
    localparam logic [STEP_W-1:0] S_TRM      = 4'd10;
    localparam logic [STEP_W-1:0] S_TRM_KILL = 4'd11;
    localparam logic [STEP_W-1:0] S_TRM_SC   = 4'd12;
    localparam logic [STEP_W-1:0] S_ERR      = 4'd13;
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd14;

    function automatic logic [STEP_W-1:0] f_entry(input logic [OP_W-1:0] op);
        logic [STEP_W-1:0] s;
        unique case (op)
            REQ_VERSION:   s = S_VER;
            REQ_CREATE:    s = S_CRE;
            REQ_YIELD:     s = S_YLD;
            REQ_TERMINATE: s = S_TRM;
            default:       s = S_ILL;
        endcase
        return s;
    endfunction

    function automatic t_uword f_uw(input t_dp_op op, input t_kind kind, input t_cond cond,
                                    input t_pred pred, input logic [STEP_W-1:0] a,
                                    input logic [STEP_W-1:0] b);
        t_uword w;
        w.op    = op;
        w.kind  = kind;
        w.cond  = cond;
        w.pred  = pred;
        w.tgt_a = a;
        w.tgt_b = b;
        return w;
    endfunction

    // Control store
    function automatic t_uword f_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            S_VER:      w = f_uw(OP_SET_VER, K_GOTO, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            S_ILL:      w = f_uw(OP_SET_ILL, K_GOTO, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            S_CRE:      w = f_uw(OP_SCAN_INIT, K_IF, C_PROG_BAD, PR_NONE, S_ERR, S_ERR);
            S_CRE_PSC:  w = f_uw(OP_NONE, K_SCAN, C_PROG_BAD, PR_P_FREE, S_CRE_LAT, S_ERR);
            S_CRE_LAT:  w = f_uw(OP_LATCH_PROC, K_NEXT, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            S_CRE_TSC:  w = f_uw(OP_NONE, K_SCAN, C_PROG_BAD, PR_T_FREE, S_CRE_COM, S_ERR);
            S_CRE_COM:  w = f_uw(OP_COMMIT, K_GOTO, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            S_YLD:      w = f_uw(OP_SCAN_INIT_RR, K_NEXT, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            S_YLD_SC:   w = f_uw(OP_NONE, K_SCAN, C_PROG_BAD, PR_T_USED, S_RUN, S_ERR);
            S_RUN:      w = f_uw(OP_SET_RUN, K_GOTO, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            S_TRM:      w = f_uw(OP_NONE, K_IF, C_RUN_ABSENT, PR_NONE, S_ERR, S_ERR);
            S_TRM_KILL: w = f_uw(OP_KILL, K_NEXT, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            S_TRM_SC:   w = f_uw(OP_NONE, K_SCAN, C_PROG_BAD, PR_T_USED, S_RUN, S_EMIT);
            S_ERR:      w = f_uw(OP_SET_ERR, K_GOTO, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            S_EMIT:     w = f_uw(OP_NONE, K_EMIT, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
            default:    w = f_uw(OP_NONE, K_GOTO, C_PROG_BAD, PR_NONE, S_EMIT, S_EMIT);
        endcase
        return w;
    endfunction

endpackage

[rtl/tss_if.sv]
// ----------------------------------------------------------------------------
// tss_if
// Request and response channels of the thread slot scheduler.
// ----------------------------------------------------------------------------
interface tss_req_if;
    logic                       valid;
    logic                       ready;
    logic [tss_pkg::OP_W-1:0]   operation;
    logic [tss_pkg::PROG_W-1:0] program_req;

    modport source (output valid, output operation, output program_req, input ready);
    modport sink   (input valid, input operation, input program_req, output ready);
endinterface

interface tss_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tss_pkg::STATUS_W-1:0] status;
    logic [tss_pkg::WORD_W-1:0]   result_word;
    logic [tss_pkg::SLOT_W-1:0]   running_thread;
    logic                         running_valid;
    logic [tss_pkg::SLOT_W-1:0]   created_thread;
    logic [tss_pkg::SLOT_W-1:0]   created_process;

    modport source (output valid, output status, output result_word, output running_thread,
                    output running_valid, output created_thread, output created_process,
                    input ready);
    modport sink   (input valid, input status, input result_word, input running_thread,
                    input running_valid, input created_thread, input created_process,
                    output ready);
endinterface

[rtl/tss_sequencer.sv]
// ----------------------------------------------------------------------------
// tss_sequencer
// Step counter and control store; dispatches on the request code and
// walks the program, branching on datapath flags.
// ----------------------------------------------------------------------------
module tss_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tss_pkg::OP_W-1:0]    i_operation,
    input  tss_pkg::t_flags             i_flags,
    output logic                        o_idle,
    output tss_pkg::t_ctrl              o_ctrl
);
    import tss_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              n_busy;
    logic [STEP_W-1:0] n_step;
    t_uword            w_uw;
    logic              w_emit;

    assign w_uw   = f_rom(r_step);
    assign w_emit = r_busy && (w_uw.kind == K_EMIT) && !i_flags.out_busy;
    assign o_idle = !r_busy;

    always_comb begin
        o_ctrl.run      = r_busy;
        o_ctrl.op       = w_uw.op;
        o_ctrl.pred     = w_uw.pred;
        o_ctrl.scan_adv = r_busy && (w_uw.kind == K_SCAN) && !i_flags.hit;
        o_ctrl.emit     = w_emit;
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = f_entry(i_operation);
            end
        end else begin
            unique case (w_uw.kind)
                K_NEXT: n_step = r_step + 1'b1;
                K_GOTO: n_step = w_uw.tgt_a;
                K_IF: begin
                    if ((w_uw.cond == C_PROG_BAD) ? i_flags.prog_bad : i_flags.run_absent)
                        n_step = w_uw.tgt_a;
                    else
                        n_step = r_step + 1'b1;
                end
                K_SCAN: begin
                    priority if (i_flags.hit)       n_step = w_uw.tgt_a;
                    else if (i_flags.scan_last)     n_step = w_uw.tgt_b;
                    else                            n_step = r_step;
                end
                K_EMIT: begin
                    if (w_emit) n_busy = 1'b0;
                end
                default: n_step = S_EMIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= S_EMIT;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

endmodule

[rtl/tss_datapath.sv]
// ----------------------------------------------------------------------------
// tss_datapath
// Slot tables, running-thread registers, slot scan unit and the
// response register.
// ----------------------------------------------------------------------------
module tss_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tss_pkg::PROG_W-1:0]    i_program_req,
    input  tss_pkg::t_ctrl                i_ctrl,
    input  logic                          i_rsp_ready,
    output tss_pkg::t_flags               o_flags,
    output logic                          o_valid,
    output logic [tss_pkg::STATUS_W-1:0]  o_status,
    output logic [tss_pkg::WORD_W-1:0]    o_result_word,
    output logic [tss_pkg::SLOT_W-1:0]    o_running_thread,
    output logic                          o_running_valid,
    output logic [tss_pkg::SLOT_W-1:0]    o_created_thread,
    output logic [tss_pkg::SLOT_W-1:0]    o_created_process
);
    import tss_pkg::*;

    localparam logic [SCAN_W-1:0] T_LAST = SCAN_W'(THREAD_SLOTS - 1);
    localparam logic [SCAN_W-1:0] P_LAST = SCAN_W'(PROCESS_SLOTS - 1);

    // Tables
    logic [THREAD_SLOTS-1:0]  r_t_used;
    logic [PIDX_W-1:0]        r_t_owner [THREAD_SLOTS];
    logic [PROCESS_SLOTS-1:0] r_p_used;
    logic [CNT_W-1:0]         r_p_count [PROCESS_SLOTS];

    logic [TIDX_W-1:0] r_run_idx;
    logic              r_run_present;
    logic [TIDX_W-1:0] r_last;

    // Per-request working registers
    logic [PROG_W-1:0] r_prog;
    t_status           r_status;
    logic [WORD_W-1:0] r_word;
    logic [SCAN_W-1:0] r_idx;
    logic [SCAN_W-1:0] r_cnt;
    logic [SCAN_W-1:0] r_found;
    logic [PIDX_W-1:0] r_pslot;
    logic [SLOT_W-1:0] r_ctid;
    logic [SLOT_W-1:0] r_cpid;

    // Response register
    logic              r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [WORD_W-1:0] r_o_word;
    logic [SLOT_W-1:0] r_o_run;
    logic              r_o_run_v;
    logic [SLOT_W-1:0] r_o_ctid;
    logic [SLOT_W-1:0] r_o_cpid;

    logic              w_hit;
    logic [SCAN_W-1:0] w_lim;
    logic [PIDX_W-1:0] w_own;
    logic [CNT_W-1:0]  w_dec;

    assign w_lim = (i_ctrl.pred == PR_P_FREE) ? P_LAST : T_LAST;

    always_comb begin
        unique case (i_ctrl.pred)
            PR_P_FREE: w_hit = !r_p_used[r_idx[PIDX_W-1:0]];
            PR_T_FREE: w_hit = !r_t_used[r_idx[TIDX_W-1:0]];
            PR_T_USED: w_hit = r_t_used[r_idx[TIDX_W-1:0]];
            default:   w_hit = 1'b0;
        endcase
    end

    // Owner of the running thread, its count saturating at zero
    assign w_own = r_t_owner[r_run_idx];
    assign w_dec = (r_p_count[w_own] == '0) ? '0 : r_p_count[w_own] - 1'b1;

    always_comb begin
        o_flags.hit        = w_hit;
        o_flags.scan_last  = (r_cnt == w_lim);
        o_flags.prog_bad   = (32'(r_prog) >= 32'(PROGRAM_COUNT));
        o_flags.run_absent = !r_run_present;
        o_flags.out_busy   = r_o_valid && !i_rsp_ready;
    end

    // Scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_used      <= THREAD_SLOTS'(1);
            r_p_used      <= PROCESS_SLOTS'(1);
            for (int i = 0; i < THREAD_SLOTS; i++) r_t_owner[i] <= '0;
            for (int i = 0; i < PROCESS_SLOTS; i++) r_p_count[i] <= '0;
            r_p_count[0]  <= CNT_W'(1);
            r_run_idx     <= '0;
            r_run_present <= 1'b1;
            r_last        <= '0;
        end else if (i_ctrl.run) begin
            unique case (i_ctrl.op)
                OP_COMMIT: begin
                    r_t_used[r_found[TIDX_W-1:0]]  <= 1'b1;
                    r_t_owner[r_found[TIDX_W-1:0]] <= r_pslot;
                    r_p_used[r_pslot]              <= 1'b1;
                    r_p_count[r_pslot]             <= CNT_W'(1);
                end
                OP_SET_RUN: begin
                    r_run_idx     <= r_found[TIDX_W-1:0];
                    r_run_present <= 1'b1;
                    r_last        <= r_found[TIDX_W-1:0];
                end
                OP_KILL: begin
                    r_t_used[r_run_idx] <= 1'b0;
                    r_p_count[w_own]    <= w_dec;
                    if (w_dec == '0) r_p_used[w_own] <= 1'b0;
                    r_run_present <= 1'b0;
                    r_run_idx     <= '0;
                end
                default: ;
            endcase
        end
    end

    // Request working registers and scan unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_OK;
        end else if (i_start) begin
            r_prog   <= i_program_req;
            r_status <= ST_OK;
            r_word   <= '0;
            r_ctid   <= '0;
            r_cpid   <= '0;
        end else if (i_ctrl.run) begin
            if (w_hit) r_found <= r_idx;
            if (i_ctrl.scan_adv) begin
                r_idx <= (r_idx == w_lim) ? '0 : r_idx + 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            unique case (i_ctrl.op)
                OP_SET_VER: r_word <= VERSION_WORD;
                OP_SET_ILL: r_status <= ST_ILLEGAL;
                OP_SET_ERR: r_status <= ST_ERROR;
                OP_SCAN_INIT, OP_KILL: begin
                    r_idx <= '0;
                    r_cnt <= '0;
                end
                OP_LATCH_PROC: begin
                    r_pslot <= r_found[PIDX_W-1:0];
                    r_idx   <= '0;
                    r_cnt   <= '0;
                end
                OP_SCAN_INIT_RR: begin
                    r_idx <= (SCAN_W'(r_last) == T_LAST) ? '0 : SCAN_W'(r_last) + 1'b1;
                    r_cnt <= '0;
                end
                OP_COMMIT: begin
                    r_ctid <= SLOT_W'(r_found);
                    r_cpid <= SLOT_W'(r_pslot);
                end
                default: ;
            endcase
        end
    end

    // Response register: loaded only when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_o_valid  <= 1'b1;
            r_o_status <= r_status;
            r_o_word   <= r_word;
            r_o_run    <= r_run_present ? SLOT_W'(r_run_idx) : '0;
            r_o_run_v  <= r_run_present;
            r_o_ctid   <= r_ctid;
            r_o_cpid   <= r_cpid;
        end else if (i_rsp_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_result_word     = r_o_word;
    assign o_running_thread  = r_o_run;
    assign o_running_valid   = r_o_run_v;
    assign o_created_thread  = r_o_ctid;
    assign o_created_process = r_o_cpid;

endmodule

[rtl/thread_slot_scheduler.sv]
// ----------------------------------------------------------------------------
// thread_slot_scheduler
// Round-robin thread scheduler over thread and process slot tables.
// ----------------------------------------------------------------------------
// One request at a time, one response beat per request. A request runs as
// a short program from a control store; the slot scan unit tests one slot
// per cycle; create runs a process-slot scan followed by a thread-slot scan.
// The next request is taken the cycle after the response is loaded. A
// finished response waits in an output register while the next request is
// taken; if it is still held when the next response is due, the program
// waits at its emit step.
// ----------------------------------------------------------------------------
module thread_slot_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tss_req_if.sink    i_req,
    tss_rsp_if.source  o_rsp
);
    import tss_pkg::*;

    logic   w_idle;
    logic   w_start;
    t_ctrl  w_ctrl;
    t_flags w_flags;

    assign i_req.ready = w_idle;
    assign w_start     = i_req.valid && w_idle;

    tss_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_operation (i_req.operation),
        .i_flags     (w_flags),
        .o_idle      (w_idle),
        .o_ctrl      (w_ctrl)
    );

    tss_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (w_start),
        .i_program_req     (i_req.program_req),
        .i_ctrl            (w_ctrl),
        .i_rsp_ready       (o_rsp.ready),
        .o_flags           (w_flags),
        .o_valid           (o_rsp.valid),
        .o_status          (o_rsp.status),
        .o_result_word     (o_rsp.result_word),
        .o_running_thread  (o_rsp.running_thread),
        .o_running_valid   (o_rsp.running_valid),
        .o_created_thread  (o_rsp.created_thread),
        .o_created_process (o_rsp.created_process)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thread slot scheduler. Requests go in from a
// queue that is built at time zero: a short directed run through the corner
// cases, then random phases that lean towards create, terminate or a spread
// of all requests, so the slot tables fill up and empty out again. A local
// copy of the slot tables predicts each response beat, and every beat taken
// from the block is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import tss_pkg::*;

    localparam logic [OP_W-1:0] OP_ILLEGAL_LO = 3'd4;
    localparam logic [OP_W-1:0] OP_ILLEGAL_HI = 3'd7;
    localparam int RAND_ITEMS   = 400;
    localparam int GAP_LIGHT    = 26;
    localparam int GAP_HEAVY    = 45;
    localparam int SETTLE_TICKS = 40;

    typedef enum logic [1:0] {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FREE
    } t_pace;

    typedef enum logic [1:0] {
        LEAN_CREATE,
        LEAN_TERMINATE,
        LEAN_EVEN
    } t_lean;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PROG_W-1:0] prog;
        logic              hold;
        t_pace             pace;
    } t_req_item;

    typedef struct packed {
        t_status             status;
        logic [WORD_W-1:0]   word;
        logic [SLOT_W-1:0]   run_thread;
        logic                run_valid;
        logic [SLOT_W-1:0]   new_thread;
        logic [SLOT_W-1:0]   new_proc;
    } t_sched_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tss_req_if req_ch ();
    tss_rsp_if rsp_ch ();

    thread_slot_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // Predicted slot tables
    logic              thr_used     [THREAD_SLOTS];
    logic [PIDX_W-1:0] thr_proc     [THREAD_SLOTS];
    logic              proc_used    [PROCESS_SLOTS];
    logic [CNT_W-1:0]  proc_thr_cnt [PROCESS_SLOTS];
    logic [TIDX_W-1:0] run_idx;
    logic              run_on;
    logic [TIDX_W-1:0] rr_last;

    t_req_item  stim_q[$];
    t_sched_rsp rsp_expect[$];
    int         beats_in  = 0;
    int         beats_out = 0;
    int         n_items   = 0;
    int         errs      = 0;
    t_pace      pace_now  = PACE_SLOW_SINK;

    function automatic int src_gap_pct(input t_pace pc);
        case (pc)
            PACE_SLOW_SINK:   return GAP_LIGHT;
            PACE_SLOW_SOURCE: return GAP_HEAVY;
            default:          return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct(input t_pace pc);
        case (pc)
            PACE_SLOW_SINK:   return GAP_HEAVY;
            PACE_SLOW_SOURCE: return GAP_LIGHT;
            default:          return 0;
        endcase
    endfunction

    // Applies one request to the predicted tables and returns its response
    function automatic t_sched_rsp sched_apply(input logic [OP_W-1:0] op,
                                               input logic [PROG_W-1:0] prog);
        t_sched_rsp        r;
        int                i;
        int                idx;
        int                p;
        int                t;
        bit                p_hit;
        bit                t_hit;
        bit                hit;
        logic [PIDX_W-1:0] own;
        r.status     = ST_OK;
        r.word       = '0;
        r.new_thread = '0;
        r.new_proc   = '0;
        p_hit = 1'b0;
        t_hit = 1'b0;
        hit   = 1'b0;
        p     = 0;
        t     = 0;
        case (op)
            REQ_VERSION: begin
                r.word = VERSION_WORD;
            end
            REQ_CREATE: begin
                for (i = 0; i < PROCESS_SLOTS; i++)
                    if (!p_hit && !proc_used[i]) begin
                        p_hit = 1'b1;
                        p     = i;
                    end
                for (i = 0; i < THREAD_SLOTS; i++)
                    if (!t_hit && !thr_used[i]) begin
                        t_hit = 1'b1;
                        t     = i;
                    end
                if (int'(prog) >= PROGRAM_COUNT || !p_hit || !t_hit) begin
                    r.status = ST_ERROR;
                end else begin
                    thr_proc[t]     = PIDX_W'(p);
                    thr_used[t]     = 1'b1;
                    proc_thr_cnt[p] = CNT_W'(1);
                    proc_used[p]    = 1'b1;
                    r.new_thread    = SLOT_W'(t);
                    r.new_proc      = SLOT_W'(p);
                end
            end
            REQ_YIELD: begin
                // round robin, starting just past the last pick
                for (i = 1; i <= THREAD_SLOTS; i++) begin
                    idx = (int'(rr_last) + i) % THREAD_SLOTS;
                    if (!hit && thr_used[idx]) begin
                        hit     = 1'b1;
                        run_idx = TIDX_W'(idx);
                        run_on  = 1'b1;
                        rr_last = TIDX_W'(idx);
                    end
                end
                if (!hit)
                    r.status = ST_ERROR;
            end
            REQ_TERMINATE: begin
                if (!run_on) begin
                    r.status = ST_ERROR;
                end else begin
                    thr_used[run_idx] = 1'b0;
                    own = thr_proc[run_idx];
                    if (proc_thr_cnt[own] != '0)
                        proc_thr_cnt[own] = proc_thr_cnt[own] - 1'b1;
                    if (proc_thr_cnt[own] == '0)
                        proc_used[own] = 1'b0;
                    run_on  = 1'b0;
                    run_idx = '0;
                    // lowest used slot takes over; last pick kept if none
                    for (i = 0; i < THREAD_SLOTS; i++)
                        if (!hit && thr_used[i]) begin
                            hit     = 1'b1;
                            run_idx = TIDX_W'(i);
                            run_on  = 1'b1;
                            rr_last = TIDX_W'(i);
                        end
                end
            end
            default: begin
                r.status = ST_ILLEGAL;
            end
        endcase
        r.run_thread = run_on ? SLOT_W'(run_idx) : '0;
        r.run_valid  = run_on;
        return r;
    endfunction

    function automatic logic [OP_W-1:0] draw_op(input t_lean lean);
        int              r;
        logic [OP_W-1:0] op;
        r = $urandom_range(99);
        case (lean)
            LEAN_CREATE:
                op = (r < 70) ? REQ_CREATE : (r < 85) ? REQ_YIELD :
                     (r < 92) ? REQ_TERMINATE : (r < 96) ? REQ_VERSION : OP_ILLEGAL_LO;
            LEAN_TERMINATE:
                op = (r < 65) ? REQ_TERMINATE : (r < 85) ? REQ_YIELD :
                     (r < 92) ? REQ_CREATE : (r < 96) ? REQ_VERSION : OP_ILLEGAL_LO;
            default:
                op = (r < 30) ? REQ_CREATE : (r < 55) ? REQ_YIELD :
                     (r < 80) ? REQ_TERMINATE : (r < 90) ? REQ_VERSION : OP_ILLEGAL_LO;
        endcase
        if (op == OP_ILLEGAL_LO)
            op = OP_W'($urandom_range(OP_ILLEGAL_HI, OP_ILLEGAL_LO));
        return op;
    endfunction

    task automatic load(input logic [OP_W-1:0] op, input logic [PROG_W-1:0] prog,
                        input logic hold, input t_pace pc);
        t_req_item it;
        it.op   = op;
        it.prog = prog;
        it.hold = hold;
        it.pace = pc;
        stim_q.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin : drv
        logic      took;
        int        sent;
        t_req_item nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            took = req_ch.valid && req_ch.ready;
            if (took)
                rsp_expect.push_back(sched_apply(req_ch.operation, req_ch.program_req));
            sent = beats_in + (took ? 1 : 0);
            beats_in <= sent;
            if (!req_ch.valid || took) begin
                // a held item waits until every issued request has answered
                if (stim_q.size() == 0 || (stim_q[0].hold && sent != beats_out) ||
                    $urandom_range(99) < src_gap_pct(stim_q[0].pace)) begin
                    req_ch.valid <= 1'b0;
                end else begin
                    nxt = stim_q.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.operation   <= nxt.op;
                    req_ch.program_req <= nxt.prog;
                    pace_now           <= nxt.pace;
                end
            end
        end
    end

    // Response monitor
    always @(posedge i_clk) begin : mon
        t_sched_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                beats_out <= beats_out + 1;
                if (rsp_expect.size() == 0) begin
                    $error("response beat with nothing outstanding");
                    errs++;
                end else begin
                    want = rsp_expect.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(rsp_ch.status));
                    check_field("result_word", want.word, rsp_ch.result_word);
                    check_field("running_thread", WORD_W'(want.run_thread),
                                WORD_W'(rsp_ch.running_thread));
                    check_field("running_valid", WORD_W'(want.run_valid),
                                WORD_W'(rsp_ch.running_valid));
                    check_field("created_thread", WORD_W'(want.new_thread),
                                WORD_W'(rsp_ch.created_thread));
                    check_field("created_process", WORD_W'(want.new_proc),
                                WORD_W'(rsp_ch.created_process));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct(pace_now));
        end
    end

    initial begin : main
        int    i;
        int    n_rand;
        int    span;
        int    ph;
        t_lean lean;
        t_pace pc;
        req_ch.valid       = 1'b0;
        req_ch.operation   = REQ_VERSION;
        req_ch.program_req = '0;
        rsp_ch.ready       = 1'b0;

        for (i = 0; i < THREAD_SLOTS; i++) begin
            thr_used[i] = (i == 0);
            thr_proc[i] = '0;
        end
        for (i = 0; i < PROCESS_SLOTS; i++) begin
            proc_used[i]    = (i == 0);
            proc_thr_cnt[i] = (i == 0) ? CNT_W'(1) : '0;
        end
        run_idx = '0;
        run_on  = 1'b1;
        rr_last = '0;

        // directed: codes, round robin, drain to empty, errors on empty
        load(REQ_VERSION,   4'd0,  1'b0, PACE_SLOW_SINK);
        for (i = 0; i <= int'(OP_ILLEGAL_HI - OP_ILLEGAL_LO); i++)
            load(OP_ILLEGAL_LO + OP_W'(i), (i % 2 == 0) ? 4'd15 : 4'd0, 1'b0,
                 PACE_SLOW_SINK);
        load(REQ_YIELD,     4'd0,  1'b0, PACE_SLOW_SINK);
        load(REQ_CREATE,    4'd15, 1'b0, PACE_SLOW_SINK);
        load(REQ_CREATE,    4'd0,  1'b0, PACE_SLOW_SINK);
        load(REQ_YIELD,     4'd3,  1'b0, PACE_SLOW_SINK);
        load(REQ_YIELD,     4'd12, 1'b0, PACE_SLOW_SINK);
        load(REQ_YIELD,     4'd0,  1'b0, PACE_SLOW_SINK);
        load(REQ_TERMINATE, 4'd0,  1'b0, PACE_SLOW_SINK);
        load(REQ_TERMINATE, 4'd0,  1'b0, PACE_SLOW_SINK);
        load(REQ_TERMINATE, 4'd0,  1'b0, PACE_SLOW_SINK);
        load(REQ_TERMINATE, 4'd0,  1'b1, PACE_SLOW_SINK);
        load(REQ_YIELD,     4'd0,  1'b0, PACE_SLOW_SINK);
        load(REQ_CREATE,    4'd5,  1'b0, PACE_SLOW_SINK);
        load(REQ_YIELD,     4'd10, 1'b0, PACE_SLOW_SINK);
        load(REQ_VERSION,   4'd15, 1'b0, PACE_SLOW_SINK);

        // random phases cycle through fill, drain and an even spread
        n_rand = 0;
        ph     = 0;
        while (n_rand < RAND_ITEMS) begin
            span = $urandom_range(50, 20);
            lean = t_lean'(ph % 3);
            for (i = 0; i < span && n_rand < RAND_ITEMS; i++) begin
                pc = (n_rand < RAND_ITEMS / 3)     ? PACE_SLOW_SINK :
                     (n_rand < 2 * RAND_ITEMS / 3) ? PACE_SLOW_SOURCE : PACE_FREE;
                load(draw_op(lean), PROG_W'($urandom_range(15, 0)),
                     (n_rand == 0) || (i == 0 && $urandom_range(1, 0) == 1), pc);
                n_rand++;
            end
            ph++;
        end
        n_items = stim_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_in != n_items || beats_out != beats_in)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (rsp_expect.size() != 0) begin
            $error("%0d responses never arrived", rsp_expect.size());
            errs++;
        end
        if (errs == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/tss_sequencer.sv
rtl/tss_datapath.sv
rtl/thread_slot_scheduler.sv
tb/tb_top.sv
